>>> sv/wcpc_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// wcpc_pkg: shared types and constants of the wash cycle phase controller
// Request and response layouts, register reset values and helper functions.
// ---------------------------------------------------------------------------
package wcpc_pkg;

  // Number of wash phases (supply, wash, rinse, spin) and selectable loads
  localparam int unsigned Phases = 4;
  localparam int unsigned Loads  = 3;

  // Longest phase in seconds, so the total always fits two digits
  localparam logic [7:0] MaxPhaseSeconds = 8'd24;
  localparam logic [6:0] MaxTotal        = 7'd127;

  // Register reset values
  localparam logic [31:0] PhaseTimesLowRst  = 32'd50463489;
  localparam logic [31:0] PhaseTimesMidRst  = 32'd100992770;
  localparam logic [31:0] PhaseTimesHighRst = 32'd151325187;
  localparam logic [16:0] TicksPerSecondRst = 17'd15625;

  // Register indexes on the configuration port
  localparam logic [1:0] RegPhaseTimesLow  = 2'd0;
  localparam logic [1:0] RegPhaseTimesMid  = 2'd1;
  localparam logic [1:0] RegPhaseTimesHigh = 2'd2;
  localparam logic [1:0] RegTicksPerSecond = 2'd3;

  // Request layout
  typedef struct packed {
    logic [1:0] mode;
    logic [1:0] load_choice;
  } wcpc_req_t;

  // Response layout
  typedef struct packed {
    logic [3:0] phase_leds;
    logic       on_lamp;
    logic       pause_lamp;
    logic [1:0] load_lamps;
    logic       digit_select;
    logic [3:0] digit_value;
    logic [6:0] seconds_left;
  } wcpc_rsp_t;

  // Clamped duration of one phase from a packed duration word
  function automatic logic [4:0] phase_dur(input logic [31:0] word, input logic [1:0] p);
    logic [7:0] raw;
    raw = word[8*p +: 8];
    if (raw > MaxPhaseSeconds) begin
      return MaxPhaseSeconds[4:0];
    end
    return raw[4:0];
  endfunction

  // Total countdown of one load, saturated to seven bits
  function automatic logic [6:0] total_dur(input logic [31:0] word);
    logic [8:0] sum;
    sum = '0;
    for (int p = 0; p < Phases; p++) begin
      sum = sum + 9'(phase_dur(word, 2'(p)));
    end
    if (sum > 9'(MaxTotal)) begin
      return MaxTotal;
    end
    return sum[6:0];
  endfunction

  // Divide a seven-bit count by ten through a reciprocal multiply
  function automatic logic [3:0] div10(input logic [6:0] c);
    logic [14:0] prod;
    prod = 15'(c) * 15'd205;
    return prod[14:11];
  endfunction

endpackage

>>> sv/wash_cycle_phase_controller.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// wash_cycle_phase_controller: washer cycle phase controller
// Takes tick, load, start/pause and refresh requests, runs the countdown and
// drives the phase, status and display lamps.
// ---------------------------------------------------------------------------
// The response register loads at the edge a request is taken.
// One request per cycle, one next-state pass each, unless a response is held.
// The response register lets a new request in while its response is taken.
// Reset (rst_ni low, asynchronous): idle, no load, count 0, display shows
// zeros, registers return to their default durations and tick rate.
module wash_cycle_phase_controller (
  input  logic                clk_i,
  input  logic                rst_ni,
  // request channel
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  wcpc_pkg::wcpc_req_t in_req_i,
  // response channel
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output wcpc_pkg::wcpc_rsp_t out_rsp_o,
  // configuration port
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [3:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  // Request codes
  localparam logic [1:0] ModeTick    = 2'd0;
  localparam logic [1:0] ModeLoad    = 2'd1;
  localparam logic [1:0] ModeStart   = 2'd2;
  localparam logic [1:0] ModeRefresh = 2'd3;

  // Run state codes
  localparam logic [1:0] StIdle  = 2'd0;
  localparam logic [1:0] StArmed = 2'd1;
  localparam logic [1:0] StRun   = 2'd2;
  localparam logic [1:0] StPause = 2'd3;

  logic [31:0] times_q [wcpc_pkg::Loads];
  logic [16:0] tps_q;

  logic [1:0]  run_q, run_d;
  logic [1:0]  load_q, load_d;
  logic [6:0]  count_q, count_d;
  logic [1:0]  phase_q, phase_d;
  logic [16:0] subsec_q, subsec_d;
  logic        toggle_q, toggle_d;
  logic        shown_q, shown_d;
  logic [3:0]  lamp_q, lamp_d;

  logic                out_valid_q;
  wcpc_pkg::wcpc_rsp_t out_rsp_q, rsp_d;

  logic        take;
  logic        cfg_wr;
  logic [1:0]  cfg_idx;
  logic [16:0] tick_lim;
  logic [17:0] subsec_inc;
  logic [31:0] run_word;
  logic [31:0] load_word;
  logic [4:0]  run_dur [wcpc_pkg::Phases];
  logic [6:0]  run_total;
  logic [6:0]  elapsed;
  logic [6:0]  upper;
  logic [6:0]  lower;
  logic [6:0]  count_dec;
  logic [3:0]  tens;
  logic [3:0]  tens_digit;
  logic [3:0]  units;

  // Configuration writes and reads
  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite & pready;
  assign cfg_idx = paddr[3:2];

  always_comb begin
    unique case (cfg_idx)
      wcpc_pkg::RegPhaseTimesLow:  prdata = times_q[0];
      wcpc_pkg::RegPhaseTimesMid:  prdata = times_q[1];
      wcpc_pkg::RegPhaseTimesHigh: prdata = times_q[2];
      wcpc_pkg::RegTicksPerSecond: prdata = {15'd0, tps_q};
      default:                     prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      times_q[0] <= wcpc_pkg::PhaseTimesLowRst;
      times_q[1] <= wcpc_pkg::PhaseTimesMidRst;
      times_q[2] <= wcpc_pkg::PhaseTimesHighRst;
      tps_q      <= wcpc_pkg::TicksPerSecondRst;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        wcpc_pkg::RegPhaseTimesLow:  times_q[0] <= pwdata;
        wcpc_pkg::RegPhaseTimesMid:  times_q[1] <= pwdata;
        wcpc_pkg::RegPhaseTimesHigh: times_q[2] <= pwdata;
        wcpc_pkg::RegTicksPerSecond: tps_q      <= pwdata[16:0];
        default: ;
      endcase
    end
  end

  // Accept a request whenever the response slot is free or being drained
  assign in_ready_o = ~out_valid_q | out_ready_i;
  assign take       = in_valid_i & in_ready_o;

  // Durations of the running load and of the chosen load
  always_comb begin
    run_word = times_q[0];
    if (load_q == 2'd2) begin
      run_word = times_q[1];
    end else if (load_q == 2'd3) begin
      run_word = times_q[2];
    end
    load_word = times_q[0];
    if (in_req_i.load_choice == 2'd1) begin
      load_word = times_q[1];
    end else if (in_req_i.load_choice == 2'd2) begin
      load_word = times_q[2];
    end
  end

  // Window of the current phase: (lower, upper] in remaining seconds
  always_comb begin
    elapsed = '0;
    for (int p = 0; p < wcpc_pkg::Phases; p++) begin
      run_dur[p] = wcpc_pkg::phase_dur(run_word, 2'(p));
      if (2'(p) < phase_q) begin
        elapsed = elapsed + 7'(run_dur[p]);
      end
    end
    run_total = wcpc_pkg::total_dur(run_word);
    upper     = run_total - elapsed;
    lower     = upper - 7'(run_dur[phase_q]);
  end

  // Sub-second counting
  assign tick_lim   = (tps_q == '0) ? 17'd1 : tps_q;
  assign subsec_inc = 18'(subsec_q) + 18'd1;
  assign count_dec  = count_q - 7'd1;

  // Next state for one request
  always_comb begin
    run_d    = run_q;
    load_d   = load_q;
    count_d  = count_q;
    phase_d  = phase_q;
    subsec_d = subsec_q;
    toggle_d = toggle_q;
    shown_d  = shown_q;
    lamp_d   = lamp_q;
    unique case (in_req_i.mode)
      ModeTick: begin
        if (run_q == StRun) begin
          if (subsec_inc >= 18'(tick_lim)) begin
            subsec_d = '0;
            if (count_q != '0) begin
              count_d = count_dec;
              if (count_dec == '0) begin
                // finish the cycle and fall back to idle
                run_d   = StIdle;
                load_d  = '0;
                phase_d = '0;
                shown_d = 1'b0;
                lamp_d  = '0;
              end else if ((phase_q != 2'(wcpc_pkg::Phases - 1)) && (load_q != '0) &&
                           !((count_dec <= upper) && (count_dec > lower))) begin
                // advance once the count leaves the phase window
                phase_d = phase_q + 2'd1;
                lamp_d  = 4'd1 << (phase_q + 2'd1);
              end
            end
          end else begin
            subsec_d = subsec_inc[16:0];
          end
        end
      end
      ModeLoad: begin
        if (((run_q == StIdle) || (run_q == StArmed)) &&
            (in_req_i.load_choice < 2'(wcpc_pkg::Loads))) begin
          load_d  = in_req_i.load_choice + 2'd1;
          count_d = wcpc_pkg::total_dur(load_word);
          phase_d = '0;
          run_d   = StArmed;
        end
      end
      ModeStart: begin
        if (run_q == StArmed) begin
          if (count_q != '0) begin
            subsec_d = '0;
            phase_d  = '0;
            lamp_d   = 4'd1;
            run_d    = StRun;
            shown_d  = 1'b1;
          end
        end else if (run_q == StRun) begin
          run_d = StPause;
        end else if (run_q == StPause) begin
          run_d = StRun;
        end
      end
      ModeRefresh: begin
        toggle_d = ~toggle_q;
      end
      default: ;
    endcase
  end

  // Split the new count into display digits
  assign tens       = wcpc_pkg::div10(count_d);
  assign tens_digit = (tens >= 4'd10) ? (tens - 4'd10) : tens;
  assign units      = 4'(count_d - 7'(tens) * 7'd10);

  // Build the response from the state after the request
  always_comb begin
    rsp_d.phase_leds   = lamp_d;
    rsp_d.on_lamp      = (run_d == StRun);
    rsp_d.pause_lamp   = (run_d == StPause);
    rsp_d.load_lamps   = load_d;
    rsp_d.digit_select = toggle_d;
    rsp_d.seconds_left = count_d;
    if (!shown_d) begin
      rsp_d.digit_value = '0;
    end else if (toggle_d) begin
      rsp_d.digit_value = tens_digit;
    end else begin
      rsp_d.digit_value = units;
    end
  end

  // Update state on each taken request
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q    <= StIdle;
      load_q   <= '0;
      count_q  <= '0;
      phase_q  <= '0;
      subsec_q <= '0;
      toggle_q <= 1'b0;
      shown_q  <= 1'b0;
      lamp_q   <= '0;
    end else if (take) begin
      run_q    <= run_d;
      load_q   <= load_d;
      count_q  <= count_d;
      phase_q  <= phase_d;
      subsec_q <= subsec_d;
      toggle_q <= toggle_d;
      shown_q  <= shown_d;
      lamp_q   <= lamp_d;
    end
  end

  // Hold the response until it is taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (take) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      out_rsp_q <= rsp_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

endmodule

>>> tb/sv/wash_cycle_phase_controller_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// wash_cycle_phase_controller_tb: self-checking bench of the washer controller
// Drives tick, load, start/pause and refresh requests with random gaps and
// random output stalls, reprograms the phase durations and tick rate between
// runs, and compares every panel response with an in-bench model of the
// countdown, phase lamps and display multiplexing.
// ---------------------------------------------------------------------------
module wash_cycle_phase_controller_tb;

  localparam int CycleLimit = 1000000;
  localparam int HoldAfter  = 700;   // responses seen before the long stall
  localparam int HoldCycles = 320;

  // Request kinds carried in the mode field
  typedef enum logic [1:0] {
    EvTick    = 2'd0,
    EvLoad    = 2'd1,
    EvPress   = 2'd2,
    EvRefresh = 2'd3
  } wash_event_e;

  // Washer run states
  typedef enum logic [1:0] {
    StIdle    = 2'd0,
    StArmed   = 2'd1,
    StRunning = 2'd2,
    StPaused  = 2'd3
  } wash_run_e;

  // Panel model: tracks the washer state and queues the expected panels
  class panel_tracker;
    logic [31:0] dur_word [3];
    logic [16:0] tick_rate;
    wash_run_e   run;
    logic [1:0]  load_sel;      // 0 none, else chosen load plus one
    int          count;
    logic [1:0]  phase;
    int unsigned sub;
    bit          tens_sel;
    bit          shown;
    logic [3:0]  lamp;
    wcpc_pkg::wcpc_rsp_t panel_due [$];
    int          errors;
    int          panels_seen;

    function new();
      dur_word[0] = wcpc_pkg::PhaseTimesLowRst;
      dur_word[1] = wcpc_pkg::PhaseTimesMidRst;
      dur_word[2] = wcpc_pkg::PhaseTimesHighRst;
      tick_rate   = wcpc_pkg::TicksPerSecondRst;
      clear_cycle();
      tens_sel    = 1'b0;
      errors      = 0;
      panels_seen = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [31:0] val);
      case (idx)
        wcpc_pkg::RegPhaseTimesLow:  dur_word[0] = val;
        wcpc_pkg::RegPhaseTimesMid:  dur_word[1] = val;
        wcpc_pkg::RegPhaseTimesHigh: dur_word[2] = val;
        wcpc_pkg::RegTicksPerSecond: tick_rate = val[16:0];
        default: ;
      endcase
    endfunction

    // Seconds of one phase of one load, clamped to the two-digit budget
    function int secs(int ld, int p);
      logic [7:0] raw;
      raw = 8'(dur_word[ld] >> (8 * p));
      if (raw > wcpc_pkg::MaxPhaseSeconds) return int'(wcpc_pkg::MaxPhaseSeconds);
      return int'(raw);
    endfunction

    function int cycle_total(int ld);
      int sum;
      sum = 0;
      for (int p = 0; p < wcpc_pkg::Phases; p++) sum += secs(ld, p);
      if (sum > int'(wcpc_pkg::MaxTotal)) return int'(wcpc_pkg::MaxTotal);
      return sum;
    endfunction

    function void clear_cycle();
      run      = StIdle;
      load_sel = 2'd0;
      count    = 0;
      phase    = 2'd0;
      sub      = 0;
      shown    = 1'b0;
      lamp     = 4'd0;
    endfunction

    // Advance at most one phase once the count leaves the current window
    function void step_phase();
      int ld, elapsed, upper, lower;
      if (phase + 1 >= wcpc_pkg::Phases || load_sel == 2'd0) return;
      ld      = int'(load_sel) - 1;
      elapsed = 0;
      for (int p = 0; p < int'(phase); p++) elapsed += secs(ld, p);
      upper = cycle_total(ld) - elapsed;
      lower = upper - secs(ld, int'(phase));
      if (!(count <= upper && count > lower)) begin
        phase = phase + 2'd1;
        lamp  = 4'b0001 << phase;
      end
    endfunction

    function void note_event(wcpc_pkg::wcpc_req_t ev);
      wcpc_pkg::wcpc_rsp_t want;
      int unsigned lim;
      case (wash_event_e'(ev.mode))
        EvTick: begin
          if (run == StRunning) begin
            lim = (tick_rate == 17'd0) ? 1 : int'(tick_rate);
            if (sub + 1 >= lim) begin
              sub = 0;
              if (count != 0) begin
                count--;
                if (count == 0) clear_cycle();
                else step_phase();
              end
            end else begin
              sub++;
            end
          end
        end
        EvLoad: begin
          if ((run == StIdle || run == StArmed) && ev.load_choice < wcpc_pkg::Loads) begin
            load_sel = ev.load_choice + 2'd1;
            count    = cycle_total(int'(ev.load_choice));
            phase    = 2'd0;
            run      = StArmed;
          end
        end
        EvPress: begin
          case (run)
            StArmed: begin
              if (count != 0) begin
                sub   = 0;
                phase = 2'd0;
                lamp  = 4'b0001;
                run   = StRunning;
                shown = 1'b1;
              end
            end
            StRunning: run = StPaused;
            StPaused:  run = StRunning;
            default: ;
          endcase
        end
        default: tens_sel = !tens_sel;
      endcase

      want.phase_leds   = lamp;
      want.on_lamp      = (run == StRunning);
      want.pause_lamp   = (run == StPaused);
      want.load_lamps   = load_sel;
      want.digit_select = tens_sel;
      if (!shown) want.digit_value = 4'd0;
      else if (tens_sel) want.digit_value = 4'((count / 10) % 10);
      else want.digit_value = 4'(count % 10);
      want.seconds_left = 7'(count);
      panel_due.push_back(want);
    endfunction

    function void cmp(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        errors++;
      end
    endfunction

    function void check_panel(wcpc_pkg::wcpc_rsp_t got);
      wcpc_pkg::wcpc_rsp_t want;
      panels_seen++;
      if (panel_due.size() == 0) begin
        $error("panel response with no request pending");
        errors++;
        return;
      end
      want = panel_due.pop_front();
      cmp("phase_leds", 32'(want.phase_leds), 32'(got.phase_leds));
      cmp("on_lamp", 32'(want.on_lamp), 32'(got.on_lamp));
      cmp("pause_lamp", 32'(want.pause_lamp), 32'(got.pause_lamp));
      cmp("load_lamps", 32'(want.load_lamps), 32'(got.load_lamps));
      cmp("digit_select", 32'(want.digit_select), 32'(got.digit_select));
      cmp("digit_value", 32'(want.digit_value), 32'(got.digit_value));
      cmp("seconds_left", 32'(want.seconds_left), 32'(got.seconds_left));
    endfunction
  endclass

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                in_valid_i  = 1'b0;
  logic                in_ready_o;
  wcpc_pkg::wcpc_req_t in_req_i    = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  wcpc_pkg::wcpc_rsp_t out_rsp_o;
  logic                psel        = 1'b0;
  logic                penable     = 1'b0;
  logic                pwrite      = 1'b0;
  logic [3:0]          paddr       = '0;
  logic [31:0]         pwdata      = '0;
  logic [31:0]         prdata;
  logic                pready;

  panel_tracker tracker = new();
  int           calm    = 0;

  wash_cycle_phase_controller dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_rsp_o   (out_rsp_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Check responses before noting requests taken at the same edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) tracker.check_panel(out_rsp_o);
      if (in_valid_i && in_ready_o) tracker.note_event(in_req_i);
    end
  end

  // Offer one request; valid stays high on return until the caller moves on
  task automatic send_event(input wcpc_pkg::wcpc_req_t ev);
    int gap;
    bit took;
    if (calm > 0) begin
      calm--;
      gap = 0;
    end else begin
      if ($urandom_range(0, 59) == 0) calm = $urandom_range(20, 60);
      gap = pick_gap();
    end
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_req_i   <= ev;
    do begin
      @(negedge clk_i);
      took = in_ready_o;
      @(posedge clk_i);
    end while (!took);
  endtask

  task automatic send_ev(input wash_event_e m, input logic [1:0] c);
    wcpc_pkg::wcpc_req_t ev;
    ev.mode        = m;
    ev.load_choice = c;
    send_event(ev);
  endtask

  // Drop valid and wait until every response is back
  task automatic quiesce();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (tracker.panel_due.size() != 0) @(posedge clk_i);
  endtask

  // Setup cycle, then access cycle; the register loads at the access edge
  task automatic reg_write(input logic [1:0] idx, input logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    tracker.set_reg(idx, val);
  endtask

  task automatic apb_release();
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Random durations: mostly short, some clamped, some zero
  function automatic logic [31:0] pick_word(input int ph, input int slot);
    logic [31:0] w;
    int r;
    if (ph == 6) return '1;
    if (ph == 8 && slot == 0) return '0;
    for (int b = 0; b < 4; b++) begin
      r = $urandom_range(0, 9);
      if (r < 6) w[8*b +: 8] = 8'($urandom_range(0, 6));
      else if (r < 8) w[8*b +: 8] = 8'($urandom_range(7, 24));
      else if (r < 9) w[8*b +: 8] = 8'($urandom_range(25, 255));
      else w[8*b +: 8] = 8'd0;
    end
    return w;
  endfunction

  task automatic new_setting(input int ph);
    logic [31:0] rate;
    case (ph)
      2:       rate = 32'd0;
      4:       rate = 32'd65536;
      9:       rate = 32'd1;
      default: rate = 32'($urandom_range(1, 3));
    endcase
    reg_write(wcpc_pkg::RegPhaseTimesLow, pick_word(ph, 0));
    reg_write(wcpc_pkg::RegPhaseTimesMid, pick_word(ph, 1));
    reg_write(wcpc_pkg::RegPhaseTimesHigh, pick_word(ph, 2));
    reg_write(wcpc_pkg::RegTicksPerSecond, rate);
    apb_release();
  endtask

  // Weight the request mix by the washer state so cycles run to the end
  function automatic wcpc_pkg::wcpc_req_t pick_event();
    wcpc_pkg::wcpc_req_t ev;
    int w;
    ev.load_choice = ($urandom_range(0, 7) == 0) ? 2'd3 : 2'($urandom_range(0, 2));
    w = $urandom_range(0, 99);
    case (tracker.run)
      StIdle, StArmed: begin
        if (w < 40) ev.mode = EvLoad;
        else if (w < 75) ev.mode = EvPress;
        else if (w < 90) ev.mode = EvTick;
        else ev.mode = EvRefresh;
      end
      StRunning: begin
        if (w < 72) ev.mode = EvTick;
        else if (w < 86) ev.mode = EvRefresh;
        else if (w < 93) ev.mode = EvPress;
        else ev.mode = EvLoad;
      end
      default: begin
        if (w < 35) ev.mode = EvPress;
        else if (w < 65) ev.mode = EvTick;
        else if (w < 85) ev.mode = EvRefresh;
        else ev.mode = EvLoad;
      end
    endcase
    return ev;
  endfunction

  // Response side: random stalls and bursts, plus one long hold-off
  initial begin : result_sink
    int  stall;
    int  burst;
    bit  held;
    stall = 0;
    burst = 0;
    held  = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (!held && tracker.panels_seen >= HoldAfter) begin
        held  = 1'b1;
        stall = HoldCycles;
        burst = 0;
      end
      if (stall == 0 && burst == 0) begin
        stall = pick_gap();
        burst = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 12);
      end
      if (stall > 0) begin
        stall--;
        out_ready_i <= 1'b0;
      end else begin
        burst--;
        out_ready_i <= 1'b1;
      end
    end
  end

  initial begin : watchdog
    for (int n = 0; n < CycleLimit; n++) @(posedge clk_i);
    $display("Verification failed");
    $finish;
  end

  initial begin : stimulus
    int n_items;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Default durations: idle press, bad load, arm, start, pause, ignored loads, resume
    send_ev(EvRefresh, 2'd0);
    send_ev(EvPress, 2'd0);
    send_ev(EvTick, 2'd0);
    send_ev(EvLoad, 2'd3);
    send_ev(EvLoad, 2'd0);
    send_ev(EvLoad, 2'd2);
    send_ev(EvRefresh, 2'd1);
    send_ev(EvPress, 2'd2);
    send_ev(EvTick, 2'd3);
    send_ev(EvTick, 2'd3);
    send_ev(EvRefresh, 2'd0);
    send_ev(EvPress, 2'd1);
    send_ev(EvTick, 2'd0);
    send_ev(EvLoad, 2'd1);
    send_ev(EvPress, 2'd0);
    send_ev(EvLoad, 2'd0);
    quiesce();

    // Zero-length low load, one second per phase, clamped high load, zero rate
    reg_write(wcpc_pkg::RegPhaseTimesLow, 32'h0000_0000);
    reg_write(wcpc_pkg::RegPhaseTimesMid, 32'h0101_0101);
    reg_write(wcpc_pkg::RegPhaseTimesHigh, 32'hFFFF_FFFF);
    reg_write(wcpc_pkg::RegTicksPerSecond, 32'd0);
    apb_release();
    send_ev(EvLoad, 2'd0);
    send_ev(EvPress, 2'd0);
    send_ev(EvLoad, 2'd1);
    send_ev(EvPress, 2'd0);
    repeat (4) send_ev(EvTick, 2'd0);
    send_ev(EvRefresh, 2'd0);

    // Random runs, each under a fresh setting
    for (int ph = 0; ph < 11; ph++) begin
      quiesce();
      new_setting(ph);
      n_items = (ph == 4) ? 30 : 150;
      for (int i = 0; i < n_items; i++) send_event(pick_event());
    end

    quiesce();
    repeat (4) @(posedge clk_i);
    if (tracker.errors == 0 && tracker.panel_due.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

>>> wash_cycle_phase_controller.f
sv/wcpc_pkg.sv
sv/wash_cycle_phase_controller.sv
tb/sv/wash_cycle_phase_controller_tb.sv
